/* hdl/pms_pkg.sv */
// shared constants and command codes for the packed multiset table
package pms_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int VALUE_W   = 16;
    localparam int CMD_W     = 2;
    localparam int CNT_W     = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd2;

endpackage

/* hdl/pms_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module pms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/packed_multiset_table.sv */
// packed multiset table: slot list in a ram, scanned one entry per cycle
// insert and no-op are settled on the input beat; the result passes through the done state to the output register
// count and delete scan the slot list from slot 0; one ram read per cycle
// throughput: one command at a time, next beat taken once the result is registered
// reset: synchronous, clears the fill count and control; slot contents stay undefined
// a finished result waits in the output register while the next command is taken
module packed_multiset_table #(
    parameter int SLOTS = pms_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [pms_pkg::CMD_W-1:0]   i_cmd,
    input  logic [pms_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_ok,
    output logic [pms_pkg::CNT_W-1:0]   o_occurrences,
    output logic [pms_pkg::CNT_W-1:0]   o_fill
);
    import pms_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int FW = $clog2(SLOTS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [FW-1:0]      r_fill, n_fill;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [AW-1:0]      r_idx, n_idx;
    logic [FW-1:0]      r_cnt, n_cnt;
    logic               r_ok, n_ok;
    logic               r_out_valid, n_out_valid;
    logic               r_out_ok, n_out_ok;
    logic [CNT_W-1:0]   r_out_occ, n_out_occ;
    logic [CNT_W-1:0]   r_out_fill, n_out_fill;

    logic               w_in_beat;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [VALUE_W-1:0] w_wr_data;
    logic [AW-1:0]      w_rd_addr;
    logic [VALUE_W-1:0] w_rd_data;
    logic               w_match;
    logic               w_last;
    logic               w_shift_last;

    pms_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_ready      = (r_state == S_IDLE);
    assign w_in_beat    = i_valid && o_ready;
    assign w_match      = (w_rd_data == r_value);
    assign w_last       = (FW'(r_idx) == r_fill - FW'(1));
    assign w_shift_last = (FW'(r_idx) + FW'(2) == r_fill);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cmd       = r_cmd;
        n_value     = r_value;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_occ   = r_out_occ;
        n_out_fill  = r_out_fill;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_fill[AW-1:0];
        w_wr_data   = i_value;
        w_rd_addr   = r_idx + AW'(1);

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                w_rd_addr = '0;
                if (w_in_beat) begin
                    n_cmd   = i_cmd;
                    n_value = i_value;
                    n_idx   = '0;
                    n_cnt   = '0;
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                    case (i_cmd)
                        CMD_INSERT: begin
                            if (r_fill < FW'(SLOTS)) begin
                                w_wr_en = 1'b1;
                                n_fill  = r_fill + FW'(1);
                                n_ok    = 1'b1;
                            end
                        end
                        CMD_DELETE, CMD_COUNT: begin
                            if (r_fill != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_idx = r_idx + AW'(1);
                if (r_cmd == CMD_COUNT) begin
                    if (w_match) begin
                        n_cnt = r_cnt + FW'(1);
                    end
                    if (w_last) begin
                        n_state = S_DONE;
                    end
                end else if (w_match) begin
                    n_idx = r_idx;
                    if (w_last) begin
                        n_fill  = r_fill - FW'(1);
                        n_ok    = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                // move slot idx+1 down into idx, next read two ahead
                w_rd_addr = r_idx + AW'(2);
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                w_wr_data = w_rd_data;
                n_idx     = r_idx + AW'(1);
                if (w_shift_last) begin
                    n_fill  = r_fill - FW'(1);
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_occ   = CNT_W'(r_cnt);
                    n_out_fill  = CNT_W'(r_fill);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_value    <= n_value;
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_ok       <= n_ok;
        r_out_ok   <= n_out_ok;
        r_out_occ  <= n_out_occ;
        r_out_fill <= n_out_fill;
    end

    assign o_valid       = r_out_valid;
    assign o_ok          = r_out_ok;
    assign o_occurrences = r_out_occ;
    assign o_fill        = r_out_fill;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(SLOTS))
        else $error("fill count beyond capacity");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> (r_state != S_IDLE))
        else $error("command beat did not start work");

    a_shift_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_fill >= FW'(2)))
        else $error("shift with fewer than two slots");

    a_count_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_occ != '0)) |-> !r_out_ok)
        else $error("count result flagged ok");

endmodule
